// ----- rtl/bayer_bilinear_demosaic_macros.svh -----
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_macros
// Assertion macros for the demosaic block, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BAYER_BILINEAR_DEMOSAIC_MACROS_SVH
`define BAYER_BILINEAR_DEMOSAIC_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every edge out of reset
`define BBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define BBD_ASSERT(lbl, prop, msg)
`define BBD_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/bbd_pkg.sv -----
// ----------------------------------------------------------------------------
// bbd_pkg
// Types, codes and the filter-order table of the bilinear demosaic block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbd_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_PIXEL_BITS = 16;

  localparam int FW_BITS  = 13;
  localparam int FH_BITS  = 16;
  localparam int ROW_BITS = 16;
  localparam int OUT_BITS = 16;

  // register indexes
  localparam logic [1:0] REG_CFA    = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // filter orders
  localparam logic [1:0] CFA_RGGB = 2'd0;
  localparam logic [1:0] CFA_BGGR = 2'd1;
  localparam logic [1:0] CFA_GRBG = 2'd2;
  localparam logic [1:0] CFA_GBRG = 2'd3;

  // site colors
  localparam logic [1:0] COL_RED   = 2'd0;
  localparam logic [1:0] COL_GREEN = 2'd1;
  localparam logic [1:0] COL_BLUE  = 2'd2;

  // per-item bookkeeping handed from the memory stage to the emit stage
  typedef struct packed {
    logic [3:0] pend;    // center, row end, last-row center, last-row row end
    logic       xpar_c;  // column parity of the center-column results
    logic       xpar_e;  // column parity of the row-end results
    logic       ypar;    // row parity of the upper-row results
    logic       top;     // upper-row results sit on the first frame row
    logic       left;    // center-column results sit on the first column
  } item_info_t;

  // color at position idx = {y parity, x parity} of the 2x2 cell
  function automatic logic [1:0] cfa_colour(input logic [1:0] pat, input logic [1:0] idx);
    logic [7:0] row;
    case (pat)
      CFA_RGGB: row = {COL_BLUE, COL_GREEN, COL_GREEN, COL_RED};
      CFA_BGGR: row = {COL_RED, COL_GREEN, COL_GREEN, COL_BLUE};
      CFA_GRBG: row = {COL_GREEN, COL_BLUE, COL_RED, COL_GREEN};
      CFA_GBRG: row = {COL_GREEN, COL_RED, COL_BLUE, COL_GREEN};
      default:  row = {COL_BLUE, COL_GREEN, COL_GREEN, COL_RED};
    endcase
    return row[{idx, 1'b0} +: 2];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bayer_bilinear_demosaic.sv -----
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic
// Streaming bilinear demosaic: raw Bayer samples in raster order to RGB.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  in      | in_valid, in_ready, in_pixel_value      | raw sample, one per transaction
//  out     | out_valid, out_ready, out_red/green/blue,| 0 to 4 RGB results per input,
//          | out_last_of_run, out_end_of_frame       | one per transaction
//  cfg     | psel, penable, pwrite, paddr, pwdata,   | filter order, width, height
//          | prdata, pready                          | (write while idle)
//
//  one input per cycle while the output is not stalled and each input causes at most
//  one result; an input with n results holds the emit stage until all n are sent, one
//  result per cycle while out_ready is high, out of the output register.
//  pipeline: line store read, window update, output register.
//  the line stores share one memory word per column, read and written at most once a cycle.
//  reset clears counters, pipeline valids and the config registers; the line stores
//  are not cleared and need no clearing pass.
//  a stalled output backs up into the emit stage and then stops in_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bayer_bilinear_demosaic_macros.svh"

module bayer_bilinear_demosaic
  import bbd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [15:0]         in_pixel_value,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [OUT_BITS-1:0]      out_red,
  output logic [OUT_BITS-1:0]      out_green,
  output logic [OUT_BITS-1:0]      out_blue,
  output logic                     out_last_of_run,
  output logic                     out_end_of_frame,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int PB = PIXEL_BITS;
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LW = (CW + 1 > FW_BITS) ? CW + 1 : FW_BITS;

  // ---------------------------------------------------------------- config
  logic [1:0]         cfa_pattern_r;
  logic [FW_BITS-1:0] frame_width_r;
  logic [FH_BITS-1:0] frame_height_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfa_pattern_r  <= CFA_RGGB;
      frame_width_r  <= FW_BITS'(1920);
      frame_height_r <= FH_BITS'(1080);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CFA:    cfa_pattern_r  <= pwdata[1:0];
        REG_WIDTH:  frame_width_r  <= pwdata[FW_BITS-1:0];
        REG_HEIGHT: frame_height_r <= pwdata[FH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CFA:    prdata = 32'(cfa_pattern_r);
      REG_WIDTH:  prdata = 32'(frame_width_r);
      REG_HEIGHT: prdata = 32'(frame_height_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- geometry
  logic [LW-1:0]       fw_ext, w_c, wm1;
  logic [FH_BITS-1:0]  h_c, hm1;

  always_comb begin
    fw_ext = LW'(frame_width_r);
    if (fw_ext < LW'(2))              w_c = LW'(2);
    else if (fw_ext > LW'(MAX_WIDTH)) w_c = LW'(MAX_WIDTH);
    else                              w_c = fw_ext;
    wm1 = w_c - LW'(1);
    h_c = (frame_height_r < FH_BITS'(2)) ? FH_BITS'(2) : frame_height_r;
    hm1 = h_c - FH_BITS'(1);
  end

  // ---------------------------------------------------------------- stage 0: accept
  logic [CW-1:0]       col_r, col_nxt;
  logic [ROW_BITS-1:0] row_r, row_nxt;
  logic                in_fire, row_end, last_row, any_out;
  item_info_t          info0;

  assign in_fire  = in_valid && in_ready;
  assign row_end  = LW'(col_r) >= wm1;
  assign last_row = row_r >= hm1;
  assign any_out  = row_r != '0;

  always_comb begin
    info0.pend[0] = any_out && (col_r != '0);
    info0.pend[1] = any_out && row_end;
    info0.pend[2] = any_out && last_row && (col_r != '0);
    info0.pend[3] = any_out && last_row && row_end;
    info0.xpar_c  = ~col_r[0];
    info0.xpar_e  = wm1[0];
    info0.ypar    = ~row_r[0];
    info0.top     = row_r == ROW_BITS'(1);
    info0.left    = col_r == CW'(1);
    if (row_end) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + ROW_BITS'(1);
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 1: line store
  // word = {upper row, lower row} of one column
  logic [2*PB-1:0] line_mem [MAX_WIDTH];
  logic [2*PB-1:0] rd_r;
  logic            s1_valid_r, s1_adv, s2_free;
  logic [CW-1:0]   s1_col_r;
  logic [PB-1:0]   s1_pix_r;
  item_info_t      s1_info_r;

  assign s1_adv   = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (in_fire) rd_r <= line_mem[col_r];
    if (s1_adv)  line_mem[s1_col_r] <= {rd_r[PB-1:0], s1_pix_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (in_fire) s1_valid_r <= 1'b1;
    else if (s1_adv)  s1_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col_r  <= col_r;
      s1_pix_r  <= PB'(in_pixel_value);
      s1_info_r <= info0;
    end
  end

  // ---------------------------------------------------------------- stage 2: window and emit
  logic [2:0][2:0][PB-1:0] win_r;    // [row][col], col 2 newest
  item_info_t              s2_info_r;
  logic [3:0]              pend_r, pend_nxt, pick;
  logic [1:0]              kind;
  logic                    emit, out_valid_r;

  always_comb begin
    if (pend_r[0])      kind = 2'd0;
    else if (pend_r[1]) kind = 2'd1;
    else if (pend_r[2]) kind = 2'd2;
    else                kind = 2'd3;
    pick     = 4'b0001 << kind;
    pend_nxt = pend_r & ~pick;
  end

  assign emit    = (pend_r != '0) && (!out_valid_r || out_ready);
  assign s2_free = (pend_r == '0) || (emit && pend_nxt == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else if (s1_adv) pend_r <= s1_info_r.pend;
    else if (emit)   pend_r <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_info_r <= s1_info_r;
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= rd_r[2*PB-1:PB];
      win_r[1][2] <= rd_r[PB-1:0];
      win_r[2][2] <= s1_pix_r;
    end
  end

  // neighborhood of the current result, edges replicated
  logic [2:0][PB-1:0] row_c, row_u, row_d;
  logic [PB-1:0]      self_v, hl, hr, vu, vd, ul, ur, dl, dr;
  logic               xpar, ypar;
  logic [1:0]         col, hcol;
  logic [PB+1:0]      orth_sum, diag_sum;
  logic [PB:0]        h_sum, v_sum;
  logic [PB-1:0]      red_v, green_v, blue_v;

  always_comb begin
    row_c  = kind[1] ? win_r[2] : win_r[1];
    row_u  = (kind[1] || s2_info_r.top) ? win_r[1] : win_r[0];
    row_d  = win_r[2];
    self_v = kind[0] ? row_c[2] : row_c[1];
    hl     = (kind[0] || s2_info_r.left) ? row_c[1] : row_c[0];
    hr     = row_c[2];
    vu     = kind[0] ? row_u[2] : row_u[1];
    vd     = kind[0] ? row_d[2] : row_d[1];
    ul     = (kind[0] || s2_info_r.left) ? row_u[1] : row_u[0];
    ur     = row_u[2];
    dl     = (kind[0] || s2_info_r.left) ? row_d[1] : row_d[0];
    dr     = row_d[2];

    xpar = kind[0] ? s2_info_r.xpar_e : s2_info_r.xpar_c;
    ypar = kind[1] ? ~s2_info_r.ypar : s2_info_r.ypar;
    col  = cfa_colour(cfa_pattern_r, {ypar, xpar});
    hcol = cfa_colour(cfa_pattern_r, {ypar, ~xpar});

    orth_sum = (PB+2)'(hl) + (PB+2)'(hr) + (PB+2)'(vu) + (PB+2)'(vd);
    diag_sum = (PB+2)'(ul) + (PB+2)'(ur) + (PB+2)'(dl) + (PB+2)'(dr);
    h_sum    = (PB+1)'(hl) + (PB+1)'(hr);
    v_sum    = (PB+1)'(vu) + (PB+1)'(vd);

    if (col == COL_GREEN) begin
      green_v = self_v;
      if (hcol == COL_RED) begin
        red_v  = h_sum[PB:1];
        blue_v = v_sum[PB:1];
      end else begin
        blue_v = h_sum[PB:1];
        red_v  = v_sum[PB:1];
      end
    end else if (col == COL_RED) begin
      green_v = orth_sum[PB+1:2];
      red_v   = self_v;
      blue_v  = diag_sum[PB+1:2];
    end else begin
      green_v = orth_sum[PB+1:2];
      blue_v  = self_v;
      red_v   = diag_sum[PB+1:2];
    end
  end

  // ---------------------------------------------------------------- output register
  logic [OUT_BITS-1:0] out_red_r, out_green_r, out_blue_r;
  logic                out_last_r, out_eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit)      out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_red_r   <= OUT_BITS'(red_v);
      out_green_r <= OUT_BITS'(green_v);
      out_blue_r  <= OUT_BITS'(blue_v);
      out_last_r  <= pend_nxt == '0;
      out_eof_r   <= kind == 2'd3;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red          = out_red_r;
  assign out_green        = out_green_r;
  assign out_blue         = out_blue_r;
  assign out_last_of_run  = out_last_r;
  assign out_end_of_frame = out_eof_r;

  // ---------------------------------------------------------------- assertions
  // read and write of the line store never hit the same column in one cycle
  `BBD_ASSERT_IMP(a_no_rw_collision, in_fire && s1_adv, col_r != s1_col_r, "line store read/write collision")
  // bottom-right pixel closes its transaction run
  `BBD_ASSERT_IMP(a_eof_is_last, out_valid_r && out_eof_r, out_last_r, "end_of_frame without last_of_run")
  // a full pipeline behind a stalled output must stop the input
  `BBD_ASSERT_IMP(a_backpressure, s1_valid_r && (pend_r != '0) && out_valid_r && !out_ready, !in_ready, "input taken while pipeline blocked")

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming bilinear demosaic. Raw samples are
// pushed through the input channel. A behavioral line-store/window model in the
// bench predicts every RGB pixel, and each pixel that comes out is checked
// field by field in order. Both channels idle at random. Filter order and frame
// geometry are reprogrammed between runs over the APB port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bbd_pkg::*;

  localparam int LINE_CAP    = DEF_MAX_WIDTH;
  localparam int SETTLE      = 8;     // pipeline depth plus margin
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 64;
  localparam int WIDE_COLS   = 32;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        last_of_run;
    logic        end_of_frame;
  } rgb_pixel_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_pixel_value;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;
  logic        out_last_of_run;
  logic        out_end_of_frame;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // demosaic model state
  logic [15:0] upper_line [LINE_CAP];
  logic [15:0] lower_line [LINE_CAP];
  logic [15:0] win [3][3];
  int unsigned col_pos;
  int unsigned row_pos;
  logic [1:0]  cfa_sel;
  logic [12:0] width_reg;
  logic [15:0] height_reg;

  rgb_pixel_t pending_pixels[$];
  int         fault_count = 0;
  int         stall_cycles = 0;
  bit         steady;

  bayer_bilinear_demosaic DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_value   (in_pixel_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // model
  // ---------------------------------------------------------------------------
  function automatic logic [1:0] site_colour(logic [1:0] pat, logic yp, logic xp);
    logic [1:0] tl, tr, bl, br;
    case (pat)
      CFA_RGGB: {tl, tr, bl, br} = {COL_RED, COL_GREEN, COL_GREEN, COL_BLUE};
      CFA_BGGR: {tl, tr, bl, br} = {COL_BLUE, COL_GREEN, COL_GREEN, COL_RED};
      CFA_GRBG: {tl, tr, bl, br} = {COL_GREEN, COL_RED, COL_BLUE, COL_GREEN};
      default:  {tl, tr, bl, br} = {COL_GREEN, COL_BLUE, COL_RED, COL_GREEN};
    endcase
    case ({yp, xp})
      2'b00:   return tl;
      2'b01:   return tr;
      2'b10:   return bl;
      default: return br;
    endcase
  endfunction

  // neighbor in the window, edges replicate the center sample
  function automatic logic [15:0] tap(int cr, int cc, int dr, int dc,
                                      bit top, bit bot, bit left, bit right);
    int r;
    int c;
    r = cr + dr;
    c = cc + dc;
    if ((dr < 0 && top) || (dr > 0 && bot)) r = cr;
    if ((dc < 0 && left) || (dc > 0 && right)) c = cc;
    return win[r][c];
  endfunction

  function automatic rgb_pixel_t interpolate(int cr, int cc, int unsigned x, int unsigned y,
                                             bit top, bit bot, bit left, bit right);
    rgb_pixel_t px;
    logic [1:0]  site;
    logic [15:0] self, hl, hr, vu, vd;
    logic [17:0] orth, diag;
    logic [16:0] hsum, vsum;
    site = site_colour(cfa_sel, y[0], x[0]);
    self = win[cr][cc];
    hl = tap(cr, cc, 0, -1, top, bot, left, right);
    hr = tap(cr, cc, 0, 1, top, bot, left, right);
    vu = tap(cr, cc, -1, 0, top, bot, left, right);
    vd = tap(cr, cc, 1, 0, top, bot, left, right);
    px = '0;
    if (site != COL_GREEN) begin
      orth = hl + hr + vu + vd;
      diag = tap(cr, cc, -1, -1, top, bot, left, right) + tap(cr, cc, -1, 1, top, bot, left, right)
           + tap(cr, cc, 1, -1, top, bot, left, right) + tap(cr, cc, 1, 1, top, bot, left, right);
      px.green = orth[17:2];
      if (site == COL_RED) begin
        px.red  = self;
        px.blue = diag[17:2];
      end else begin
        px.blue = self;
        px.red  = diag[17:2];
      end
    end else begin
      hsum = hl + hr;
      vsum = vu + vd;
      px.green = self;
      // horizontal neighbor's color picks which pair mean is red
      if (site_colour(cfa_sel, y[0], ~x[0]) == COL_RED) begin
        px.red  = hsum[16:1];
        px.blue = vsum[16:1];
      end else begin
        px.blue = hsum[16:1];
        px.red  = vsum[16:1];
      end
    end
    return px;
  endfunction

  // one accepted sample: shift it into the stores and queue the pixels it completes
  task automatic absorb_sample(logic [15:0] pix);
    int unsigned w, h, cx, cy;
    logic [15:0] up, lo;
    bit row_end, last_row, top;
    rgb_pixel_t batch[$];
    rgb_pixel_t corner;
    w = width_reg;
    if (w < 2) w = 2;
    if (w > LINE_CAP) w = LINE_CAP;
    h = height_reg;
    if (h < 2) h = 2;
    cx = col_pos;
    cy = row_pos;
    if (cx >= LINE_CAP) cx = LINE_CAP - 1;
    up = upper_line[cx];
    lo = lower_line[cx];
    upper_line[cx] = lo;
    lower_line[cx] = pix;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = lo;
    win[2][2] = pix;
    row_end  = cx >= w - 1;
    last_row = cy >= h - 1;
    top      = cy == 1;
    if (cy >= 1) begin
      if (cx >= 1) batch.push_back(interpolate(1, 1, cx - 1, cy - 1, top, 0, cx == 1, 0));
      if (row_end) batch.push_back(interpolate(1, 2, w - 1, cy - 1, top, 0, 0, 1));
      if (last_row) begin
        if (cx >= 1) batch.push_back(interpolate(2, 1, cx - 1, cy, 0, 1, cx == 1, 0));
        if (row_end) begin
          corner = interpolate(2, 2, w - 1, cy, 0, 1, 0, 1);
          corner.end_of_frame = 1'b1;
          batch.push_back(corner);
        end
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
    foreach (batch[i]) pending_pixels.push_back(batch[i]);
    if (row_end) begin
      col_pos = 0;
      row_pos = last_row ? 0 : (cy + 1) & 16'hFFFF;
    end else begin
      col_pos = cx + 1;
    end
  endtask

  task automatic reset_model();
    cfa_sel    = CFA_RGGB;
    width_reg  = 13'd1920;
    height_reg = 16'd1080;
    foreach (upper_line[i]) upper_line[i] = '0;
    foreach (lower_line[i]) lower_line[i] = '0;
    foreach (win[r, c]) win[r][c] = '0;
    col_pos = 0;
    row_pos = 0;
  endtask

  // ---------------------------------------------------------------------------
  // drivers (each task starts and ends just after a falling edge)
  // ---------------------------------------------------------------------------
  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_CFA:    cfa_sel = val[1:0];
      REG_WIDTH:  width_reg = val[12:0];
      REG_HEIGHT: height_reg = val[15:0];
      default:    ;
    endcase
  endtask

  task automatic set_geometry(logic [1:0] pat, int unsigned w, int unsigned h);
    cfg_write(REG_CFA, pat);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
  endtask

  task automatic send_pixel(logic [15:0] pix);
    while (!steady && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_value <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_sample(pix);
    @(negedge clk);
  endtask

  // hold the sender until every queued pixel is out and the pipeline is empty
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic finish_frame();
    while (col_pos != 0 || row_pos != 0) send_pixel(rand_pixel());
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checking and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_pixels
    rgb_pixel_t want;
    rgb_pixel_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_red, out_green, out_blue, out_last_of_run, out_end_of_frame};
      if (pending_pixels.size() == 0) begin
        if (fault_count < 10)
          $display("tb: unexpected pixel r=%h g=%h b=%h last=%b eof=%b",
                   got.red, got.green, got.blue, got.last_of_run, got.end_of_frame);
        fault_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.last_of_run !== want.last_of_run || got.end_of_frame !== want.end_of_frame) begin
          if (fault_count < 10)
            $display("tb: pixel mismatch: expected r=%h g=%h b=%h last=%b eof=%b, %s",
                     want.red, want.green, want.blue, want.last_of_run, want.end_of_frame,
                     $sformatf("got r=%h g=%h b=%h last=%b eof=%b", got.red, got.green,
                               got.blue, got.last_of_run, got.end_of_frame));
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 13);
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every filter order on the smallest frame, out-of-range sizes clamp to 2
  task automatic test_filter_orders();
    logic [15:0] corners [4][4];
    corners = '{'{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000},
                '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF},
                '{16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE},
                '{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555}};
    cfg_write(REG_WIDTH, 0);
    cfg_write(REG_HEIGHT, 1);
    for (int p = 0; p < 4; p++) begin
      cfg_write(REG_CFA, p);
      if (p == 1) cfg_write(REG_WIDTH, 1);
      if (p == 2) begin
        cfg_write(REG_WIDTH, 2);
        cfg_write(REG_HEIGHT, 2);
      end
      for (int i = 0; i < 4; i++) send_pixel(corners[p][i]);
      drain_pipeline();
    end
    // 3x3 gives one pixel with all eight real neighbours
    set_geometry(CFA_GRBG, 3, 3);
    for (int i = 0; i < 9; i++) send_pixel(16'hFFFF - 16'(i) * 16'h1111);
    drain_pipeline();
  endtask

  // width and height shrink while a frame is in progress
  task automatic test_geometry_shrink();
    set_geometry(CFA_BGGR, 6, 8);
    repeat (15) send_pixel(rand_pixel());
    drain_pipeline();
    cfg_write(REG_WIDTH, 3);
    repeat (7) send_pixel(rand_pixel());
    drain_pipeline();
    cfg_write(REG_HEIGHT, 2);
    finish_frame();
    drain_pipeline();
  endtask

  // widest width setting at full rate, no idling on either side; the first row
  // is closed by narrowing the width
  task automatic test_wide_row();
    steady = 1'b1;
    set_geometry(2'($urandom_range(0, 3)), 13'h1FFF, 2);
    repeat (WIDE_COLS - 1) send_pixel(16'($urandom));
    drain_pipeline();
    cfg_write(REG_WIDTH, WIDE_COLS);
    finish_frame();
    drain_pipeline();
    steady = 1'b0;
  endtask

  // tallest frame setting, cut short by a height below range
  task automatic test_tall_frame();
    set_geometry(CFA_GBRG, 4, 16'hFFFF);
    repeat (16) send_pixel(rand_pixel());
    drain_pipeline();
    cfg_write(REG_HEIGHT, 0);
    finish_frame();
    drain_pipeline();
  endtask

  task automatic test_random_frames();
    int sent;
    int unsigned w, h;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 4) != 0) ? $urandom_range(2, 8) : $urandom_range(9, 16);
      h = $urandom_range(2, 4);
      set_geometry(2'($urandom_range(0, 3)), w, h);
      for (int i = 0; i < w * h; i++) begin
        send_pixel(rand_pixel());
        // occasionally let the block run dry mid-frame
        if ($urandom_range(0, 24) == 0) drain_pipeline();
      end
      sent += w * h;
      drain_pipeline();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pixel_value = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    steady         = 1'b0;
    reset_model();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_filter_orders();
    test_geometry_shrink();
    test_wide_row();
    test_tall_frame();
    test_random_frames();

    drain_pipeline();
    if (fault_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bbd_pkg.sv
rtl/bayer_bilinear_demosaic.sv
test/tb.sv
